/* rtl/core/segment_intersection_test_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the segment intersection test core
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_TEST_CORE_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SIT_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define SIT_ASSERT(lbl, prop, msg)
`define SIT_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

/* rtl/core/sit_pkg.sv */
// ----------------------------------------------------------------------------
// sit_pkg
// Fixed number formats shared by the segment intersection test core.
// ----------------------------------------------------------------------------
package sit_pkg;

  // Integer bits of the slope, intercept and crossing format.
  localparam int unsigned INT_BITS   = 24;
  // Fraction bits of an input coordinate.
  localparam int unsigned COORD_FRAC = 4;

endpackage

/* rtl/core/sit_div.sv */
// ----------------------------------------------------------------------------
// sit_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module sit_div #(
  parameter int NUM_BITS = 33,
  parameter int DEN_BITS = 17,
  parameter int QUO_BITS = 33,
  parameter int PAY_BITS = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [NUM_BITS-1:0] num_i,
  input  logic [DEN_BITS-1:0] den_i,
  input  logic [PAY_BITS-1:0] pay_i,
  output logic                valid_o,
  output logic [QUO_BITS-1:0] quo_o,
  output logic [PAY_BITS-1:0] pay_o
);

  logic                v_q [QUO_BITS];
  logic [DEN_BITS-1:0] r_q [QUO_BITS];
  logic [QUO_BITS-1:0] q_q [QUO_BITS];
  logic [NUM_BITS-1:0] n_q [QUO_BITS];
  logic [DEN_BITS-1:0] d_q [QUO_BITS];
  logic [PAY_BITS-1:0] p_q [QUO_BITS];

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_stage
    logic                v_in;
    logic [DEN_BITS-1:0] r_in;
    logic [QUO_BITS-1:0] q_in;
    logic [NUM_BITS-1:0] n_in;
    logic [DEN_BITS-1:0] d_in;
    logic [PAY_BITS-1:0] p_in;
    logic [DEN_BITS:0]   t;
    logic                ge;

    if (i == 0) begin : g_first
      // Numerator bits above the quotient range seed the remainder.
      assign r_in = DEN_BITS'(num_i >> QUO_BITS);
      assign v_in = valid_i;
      assign q_in = '0;
      assign n_in = num_i;
      assign d_in = den_i;
      assign p_in = pay_i;
    end else begin : g_next
      assign r_in = r_q[i-1];
      assign v_in = v_q[i-1];
      assign q_in = q_q[i-1];
      assign n_in = n_q[i-1];
      assign d_in = d_q[i-1];
      assign p_in = p_q[i-1];
    end

    assign t  = {r_in, n_in[QUO_BITS-1-i]};
    assign ge = (t >= {1'b0, d_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i] <= ge ? DEN_BITS'(t - {1'b0, d_in}) : DEN_BITS'(t);
        q_q[i] <= QUO_BITS'({q_in, ge});
        n_q[i] <= n_in;
        d_q[i] <= d_in;
        p_q[i] <= p_in;
      end
    end
  end

  assign valid_o = v_q[QUO_BITS-1];
  assign quo_o   = q_q[QUO_BITS-1];
  assign pay_o   = p_q[QUO_BITS-1];

endmodule

/* rtl/core/sit_line.sv */
// ----------------------------------------------------------------------------
// sit_line
// Saturates a slope quotient and derives the line intercept in three stages.
// ----------------------------------------------------------------------------
module sit_line #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16,
  parameter int PAY_BITS   = 1
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  logic [COORD_BITS+FRAC_BITS:0]                 quo_i,
  input  logic                                          neg_i,
  input  logic signed [COORD_BITS-1:0]                  x0_i,
  input  logic signed [COORD_BITS-1:0]                  y0_i,
  input  logic [PAY_BITS-1:0]                           pay_i,
  output logic                                          valid_o,
  output logic signed [sit_pkg::INT_BITS+FRAC_BITS-1:0] m_o,
  output logic signed [sit_pkg::INT_BITS+FRAC_BITS-1:0] b_o,
  output logic [PAY_BITS-1:0]                           pay_o
);

  import sit_pkg::*;

  localparam int CW  = COORD_BITS;
  localparam int QW  = INT_BITS + FRAC_BITS;
  localparam int SNW = COORD_BITS + FRAC_BITS + 1;
  localparam int PMW = QW + CW;
  localparam int SW  = PMW + 2;
  localparam int RND = 2 ** COORD_FRAC - 1;
  localparam logic signed [SW-1:0] HI_S = {{(SW-QW+1){1'b0}}, {(QW-1){1'b1}}};
  localparam logic signed [SW-1:0] LO_S = ~HI_S;

  function automatic logic signed [SW-1:0] clamp(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > HI_S) begin
      r = HI_S;
    end else if (v < LO_S) begin
      r = LO_S;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic                 v1_q, v2_q, v3_q;
  logic signed [QW-1:0] m1_q, m2_q, m3_q, b3_q;
  logic signed [CW-1:0] x1_q, y1_q, y2_q;
  logic [PAY_BITS-1:0]  p1_q, p2_q, p3_q;
  logic signed [PMW-1:0] prod2_q;

  // Stage 1: sign and saturate the slope.
  logic signed [SW-1:0] qs, sv, m_sat;
  logic signed [QW-1:0] m1_d;
  assign qs    = {{(SW-SNW){1'b0}}, quo_i};
  assign sv    = neg_i ? -qs : qs;
  assign m_sat = clamp(sv);
  assign m1_d  = m_sat[QW-1:0];

  // Stage 2: slope times start x.
  logic signed [PMW-1:0] prod2_d;
  assign prod2_d = m1_q * x1_q;

  // Stage 3: drop the coordinate fraction toward zero, subtract from start y.
  logic signed [PMW-1:0] tz;
  logic signed [SW-1:0]  tz_s, yq, diff, b_sat;
  assign tz    = prod2_q[PMW-1] ? ((prod2_q + PMW'(RND)) >>> COORD_FRAC)
                                : (prod2_q >>> COORD_FRAC);
  assign tz_s  = {{(SW-PMW){tz[PMW-1]}}, tz};
  assign yq    = {{(SW-CW){y2_q[CW-1]}}, y2_q} <<< (FRAC_BITS - COORD_FRAC);
  assign diff  = yq - tz_s;
  assign b_sat = clamp(diff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q    <= m1_d;
      x1_q    <= x0_i;
      y1_q    <= y0_i;
      p1_q    <= pay_i;
      m2_q    <= m1_q;
      y2_q    <= y1_q;
      prod2_q <= prod2_d;
      p2_q    <= p1_q;
      m3_q    <= m2_q;
      b3_q    <= b_sat[QW-1:0];
      p3_q    <= p2_q;
    end
  end

  assign valid_o = v3_q;
  assign m_o     = m3_q;
  assign b_o     = b3_q;
  assign pay_o   = p3_q;

endmodule

/* rtl/core/segment_intersection_test_core.sv */
// ----------------------------------------------------------------------------
// segment_intersection_test_core
// Pipelined test of whether two line segments touch or overlap.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Contents (tdata from bit 0 up)
//  s_axis    in   first_start_x, first_start_y, first_end_x, first_end_y,
//                 second_start_x, second_start_y, second_end_x, second_end_y
//  m_axis    out  crosses (bit 0), zero padding to one byte
//
// One word is accepted every cycle while the output is not held. A word's
// result passes through the front stage, the bit-serial slope dividers, the
// line and case stages, the crossing x divider and the output stage.
// Reset clears only the valid bits of every stage; the datapath is not reset.
// A stall on m_axis freezes every stage together, so nothing is dropped or
// repeated, and a new word is still taken while the output stage is empty.
//
`include "segment_intersection_test_core_defines.svh"

module segment_intersection_test_core #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  logic [8*COORD_BITS-1:0] s_axis_tdata_i,
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // crosses, then seven zero bits
  output logic [7:0]              m_axis_tdata_o
);

  import sit_pkg::*;

  localparam int CW  = COORD_BITS;
  localparam int QW  = INT_BITS + FRAC_BITS;   // slope, intercept, crossing x
  localparam int SNW = CW + 1 + FRAC_BITS;     // slope numerator and quotient
  localparam int PMW = QW + CW;                // slope times coordinate
  localparam int SW  = PMW + 2;                // common width for compares
  localparam int XNW = QW + 1 + FRAC_BITS;     // crossing numerator
  localparam int RND = 2 ** COORD_FRAC - 1;
  localparam int OVW = QW + 2 + INT_BITS;
  localparam logic signed [SW-1:0] HI_S   = {{(SW-QW+1){1'b0}}, {(QW-1){1'b1}}};
  localparam logic signed [SW-1:0] LO_S   = ~HI_S;
  localparam logic [QW:0]          Q_HI   = {2'b00, {(QW-1){1'b1}}};
  localparam logic [QW:0]          Q_HALF = {2'b01, {(QW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [CW-1:0] xmin;
    logic signed [CW-1:0] xmax;
    logic signed [CW-1:0] ymin;
    logic signed [CW-1:0] ymax;
    logic                 vert;
    logic                 horiz;
    logic                 neg;
  } seg_t;

  typedef struct packed {
    seg_t      s;
    logic [CW:0] adx;
    logic [CW:0] ady;
  } prep_t;

  // Case flags and x ranges that ride along the crossing divider.
  typedef struct packed {
    logic                 xneg;
    logic                 ovf;
    logic                 eq;
    logic                 va;
    logic                 vc;
    logic                 ha;
    logic                 hc;
    logic                 rvv;
    logic                 rhh;
    logic                 vhit;
    logic signed [CW-1:0] axmin;
    logic signed [CW-1:0] axmax;
    logic signed [CW-1:0] cxmin;
    logic signed [CW-1:0] cxmax;
  } fin_t;

  localparam int SEGW = $bits(seg_t);
  localparam int FINW = $bits(fin_t);

  function automatic prep_t prep(input logic signed [CW-1:0] x0,
                                 input logic signed [CW-1:0] y0,
                                 input logic signed [CW-1:0] x1,
                                 input logic signed [CW-1:0] y1);
    prep_t             p;
    logic signed [CW:0] dx, dy;
    dx = {x0[CW-1], x0} - {x1[CW-1], x1};
    dy = {y0[CW-1], y0} - {y1[CW-1], y1};
    p.s.x0    = x0;
    p.s.y0    = y0;
    p.s.xmin  = (x0 < x1) ? x0 : x1;
    p.s.xmax  = (x0 < x1) ? x1 : x0;
    p.s.ymin  = (y0 < y1) ? y0 : y1;
    p.s.ymax  = (y0 < y1) ? y1 : y0;
    p.s.vert  = (dx == '0);
    p.s.horiz = (dy == '0);
    p.s.neg   = dx[CW] ^ dy[CW];
    p.adx     = dx[CW] ? -dx : dx;
    p.ady     = dy[CW] ? -dy : dy;
    return p;
  endfunction

  // Coordinate moved to the slope fraction format, widened for compares.
  function automatic logic signed [SW-1:0] to_q(input logic signed [CW-1:0] v);
    logic signed [SW-1:0] e;
    e = {{(SW-CW){v[CW-1]}}, v};
    return e <<< (FRAC_BITS - COORD_FRAC);
  endfunction

  function automatic logic signed [SW-1:0] clamp(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > HI_S) begin
      r = HI_S;
    end else if (v < LO_S) begin
      r = LO_S;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // The whole pipeline moves as one: it advances unless the output word is
  // held by the downstream side.
  logic en;
  logic out_v_q, out_q;
  assign en              = m_axis_tready_i || !out_v_q;
  assign s_axis_tready_o = en;

  // --------------------------------------------------------------------------
  // Front stage: differences, magnitudes, bounding boxes, vertical and
  // horizontal flags for both segments.
  // --------------------------------------------------------------------------
  prep_t pa_d, pc_d;
  logic  s0_v_q;
  prep_t s0_a_q, s0_c_q;

  assign pa_d = prep($signed(s_axis_tdata_i[0*CW +: CW]), $signed(s_axis_tdata_i[1*CW +: CW]),
                     $signed(s_axis_tdata_i[2*CW +: CW]), $signed(s_axis_tdata_i[3*CW +: CW]));
  assign pc_d = prep($signed(s_axis_tdata_i[4*CW +: CW]), $signed(s_axis_tdata_i[5*CW +: CW]),
                     $signed(s_axis_tdata_i[6*CW +: CW]), $signed(s_axis_tdata_i[7*CW +: CW]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_a_q <= pa_d;
      s0_c_q <= pc_d;
    end
  end

  // --------------------------------------------------------------------------
  // Slope magnitudes |dy| * 2^FRAC_BITS / |dx|, one divider per segment.
  // A vertical segment divides by zero here; its slope is never used.
  // --------------------------------------------------------------------------
  logic            da_v, dc_v;
  logic [SNW-1:0]  da_q, dc_q;
  logic [SEGW-1:0] da_p, dc_p;
  seg_t            da_s, dc_s;

  sit_div #(
    .NUM_BITS (SNW),
    .DEN_BITS (CW + 1),
    .QUO_BITS (SNW),
    .PAY_BITS (SEGW)
  ) u_div_slope_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_v_q),
    .num_i   ({s0_a_q.ady, {FRAC_BITS{1'b0}}}),
    .den_i   (s0_a_q.adx),
    .pay_i   (s0_a_q.s),
    .valid_o (da_v),
    .quo_o   (da_q),
    .pay_o   (da_p)
  );

  sit_div #(
    .NUM_BITS (SNW),
    .DEN_BITS (CW + 1),
    .QUO_BITS (SNW),
    .PAY_BITS (SEGW)
  ) u_div_slope_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_v_q),
    .num_i   ({s0_c_q.ady, {FRAC_BITS{1'b0}}}),
    .den_i   (s0_c_q.adx),
    .pay_i   (s0_c_q.s),
    .valid_o (dc_v),
    .quo_o   (dc_q),
    .pay_o   (dc_p)
  );

  assign da_s = seg_t'(da_p);
  assign dc_s = seg_t'(dc_p);

  // --------------------------------------------------------------------------
  // Saturated slope and intercept of each segment.
  // --------------------------------------------------------------------------
  logic                 la_v, lc_v;
  logic signed [QW-1:0] ma, ba, mc, bc;
  logic [SEGW-1:0]      la_p, lc_p;
  seg_t                 sa, sc;

  sit_line #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .PAY_BITS   (SEGW)
  ) u_line_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (da_v),
    .quo_i   (da_q),
    .neg_i   (da_s.neg),
    .x0_i    (da_s.x0),
    .y0_i    (da_s.y0),
    .pay_i   (da_p),
    .valid_o (la_v),
    .m_o     (ma),
    .b_o     (ba),
    .pay_o   (la_p)
  );

  sit_line #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .PAY_BITS   (SEGW)
  ) u_line_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dc_v),
    .quo_i   (dc_q),
    .neg_i   (dc_s.neg),
    .x0_i    (dc_s.x0),
    .y0_i    (dc_s.y0),
    .pay_i   (dc_p),
    .valid_o (lc_v),
    .m_o     (mc),
    .b_o     (bc),
    .pay_o   (lc_p)
  );

  assign sa = seg_t'(la_p);
  assign sc = seg_t'(lc_p);

  // --------------------------------------------------------------------------
  // Case stage 1: decide the case flags, pick the vertical segment and the
  // other one, multiply the other slope by the vertical x, and form the
  // crossing numerator and denominator as magnitudes plus a sign.
  // --------------------------------------------------------------------------
  fin_t                 h1_f_d;
  logic signed [QW:0]   n_s, d_s;
  logic signed [QW-1:0] o_m, o_b;
  logic signed [CW-1:0] vx;
  logic signed [PMW-1:0] po_d;

  assign n_s  = {bc[QW-1], bc} - {ba[QW-1], ba};
  assign d_s  = {ma[QW-1], ma} - {mc[QW-1], mc};
  assign o_m  = sa.vert ? mc : ma;
  assign o_b  = sa.vert ? bc : ba;
  assign vx   = sa.vert ? sa.xmin : sc.xmin;
  assign po_d = o_m * vx;

  always_comb begin
    h1_f_d       = '0;
    h1_f_d.xneg  = n_s[QW] ^ d_s[QW];
    h1_f_d.eq    = (ma == mc);
    h1_f_d.va    = sa.vert;
    h1_f_d.vc    = sc.vert;
    h1_f_d.ha    = sa.horiz;
    h1_f_d.hc    = sc.horiz;
    h1_f_d.rvv   = (sa.xmin == sc.xmin) && (sa.ymin <= sc.ymax) && (sc.ymin <= sa.ymax);
    h1_f_d.rhh   = (sa.ymin == sc.ymin) && (sa.xmin <= sc.xmax) && (sc.xmin <= sa.xmax);
    h1_f_d.axmin = sa.xmin;
    h1_f_d.axmax = sa.xmax;
    h1_f_d.cxmin = sc.xmin;
    h1_f_d.cxmax = sc.xmax;
  end

  logic                  h1_v_q;
  fin_t                  h1_f_q;
  logic signed [PMW-1:0] h1_po_q;
  logic signed [QW-1:0]  h1_ob_q;
  logic signed [CW-1:0]  h1_vx_q, h1_oxmin_q, h1_oxmax_q, h1_vymin_q, h1_vymax_q;
  logic [QW:0]           h1_un_q, h1_ud_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_v_q <= 1'b0;
    end else if (en) begin
      h1_v_q <= la_v && lc_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h1_f_q     <= h1_f_d;
      h1_po_q    <= po_d;
      h1_ob_q    <= o_b;
      h1_vx_q    <= vx;
      h1_oxmin_q <= sa.vert ? sc.xmin : sa.xmin;
      h1_oxmax_q <= sa.vert ? sc.xmax : sa.xmax;
      h1_vymin_q <= sa.vert ? sa.ymin : sc.ymin;
      h1_vymax_q <= sa.vert ? sa.ymax : sc.ymax;
      h1_un_q    <= n_s[QW] ? -n_s : n_s;
      h1_ud_q    <= d_s[QW] ? -d_s : d_s;
    end
  end

  // --------------------------------------------------------------------------
  // Case stage 2: finish the vertical test (other line's y at the vertical
  // x, saturated, against the vertical y span) and flag a crossing quotient
  // that is too large for the divider's quotient range.
  // --------------------------------------------------------------------------
  logic signed [PMW-1:0] tz;
  logic signed [SW-1:0]  ysum, ysat;
  logic [OVW-1:0]        ov_n, ov_d;
  fin_t                  h2_f_d;

  assign tz   = h1_po_q[PMW-1] ? ((h1_po_q + PMW'(RND)) >>> COORD_FRAC)
                               : (h1_po_q >>> COORD_FRAC);
  assign ysum = {{(SW-PMW){tz[PMW-1]}}, tz} + {{(SW-QW){h1_ob_q[QW-1]}}, h1_ob_q};
  assign ysat = clamp(ysum);
  assign ov_n = OVW'(h1_un_q);
  assign ov_d = {h1_ud_q, {(INT_BITS + 1){1'b0}}};

  always_comb begin
    h2_f_d      = h1_f_q;
    h2_f_d.ovf  = (ov_n >= ov_d);
    h2_f_d.vhit = (h1_vx_q >= h1_oxmin_q) && (h1_vx_q <= h1_oxmax_q) &&
                  (to_q(h1_vymin_q) <= ysat) && (ysat <= to_q(h1_vymax_q));
  end

  logic        h2_v_q;
  fin_t        h2_f_q;
  logic [QW:0] h2_un_q, h2_ud_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h2_v_q <= 1'b0;
    end else if (en) begin
      h2_v_q <= h1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h2_f_q  <= h2_f_d;
      h2_un_q <= h1_un_q;
      h2_ud_q <= h1_ud_q;
    end
  end

  // --------------------------------------------------------------------------
  // Crossing x magnitude |b2 - b1| * 2^FRAC_BITS / |m1 - m2|. Only the low
  // QW+1 quotient bits are formed; larger quotients were flagged above.
  // --------------------------------------------------------------------------
  logic            dx_v;
  logic [QW:0]     dx_q;
  logic [FINW-1:0] dx_p;
  fin_t            fin;

  sit_div #(
    .NUM_BITS (XNW),
    .DEN_BITS (QW + 1),
    .QUO_BITS (QW + 1),
    .PAY_BITS (FINW)
  ) u_div_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (h2_v_q),
    .num_i   ({h2_un_q, {FRAC_BITS{1'b0}}}),
    .den_i   (h2_ud_q),
    .pay_i   (h2_f_q),
    .valid_o (dx_v),
    .quo_o   (dx_q),
    .pay_o   (dx_p)
  );

  assign fin = fin_t'(dx_p);

  // --------------------------------------------------------------------------
  // Output stage: saturate the crossing x, test it against both x spans and
  // pick the answer for the case at hand.
  // --------------------------------------------------------------------------
  logic                 big, xin, res;
  logic signed [SW-1:0] qs, xs;

  assign big = fin.ovf || (fin.xneg ? (dx_q > Q_HALF) : (dx_q > Q_HI));
  assign qs  = {{(SW-QW-1){1'b0}}, dx_q};
  assign xs  = big ? (fin.xneg ? LO_S : HI_S) : (fin.xneg ? -qs : qs);
  assign xin = (to_q(fin.axmin) <= xs) && (xs <= to_q(fin.axmax)) &&
               (to_q(fin.cxmin) <= xs) && (xs <= to_q(fin.cxmax));

  always_comb begin
    if (fin.va && fin.vc) begin
      res = fin.rvv;
    end else if (fin.va || fin.vc) begin
      res = fin.vhit;
    end else if (fin.ha && fin.hc) begin
      res = fin.rhh;
    end else if (fin.eq) begin
      // Parallel sloped segments never count as touching.
      res = 1'b0;
    end else begin
      res = xin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dx_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {7'b0000000, out_q};

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `SIT_ASSERT(a_ready_when_empty, !m_axis_tvalid_o |-> s_axis_tready_o, "input stalled with empty output")
  `SIT_ASSERT(a_accept_fills_front, s_axis_tvalid_i && s_axis_tready_o |=> s0_v_q, "accepted word lost at front stage")
  `SIT_ASSERT_NEVER(a_lanes_in_step, la_v != lc_v, "segment lanes out of step")

endmodule

/* dv/tb_segment_intersection_test_core.sv */
// ----------------------------------------------------------------------------
// tb_segment_intersection_test_core
// Drives segment pairs into the core and checks each crossing flag against a
// fixed-point predictor of the intersection test, under random idling.
// ----------------------------------------------------------------------------
module tb_segment_intersection_test_core;

  localparam int CB = 16;
  localparam int FB = 16;
  localparam int NUM_DIRECTED = 22;
  localparam int NUM_RANDOM = 630;
  localparam int LATENCY = CB + 2 * FB + 33;

  typedef struct {
    longint x0, y0, xmin, xmax, ymin, ymax, m, b;
    bit     vert, horiz;
  } segment_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid_i = 1'b0;
  logic            s_axis_tready_o;
  logic [8*CB-1:0] s_axis_tdata_i = '0;
  logic            m_axis_tvalid_o;
  logic            m_axis_tready_i = 1'b0;
  logic [7:0]      m_axis_tdata_o;

  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 69;
  int          error_count = 0;
  int          words_sent = 0;
  int          words_checked = 0;
  int          crossings_seen = 0;
  bit          expected_crosses[$];

  always #6 clk_i = ~clk_i;

  segment_intersection_test_core #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  // Saturate to the signed 24-bit integer, FB-bit fraction range.
  function automatic longint sat_q(longint v);
    longint hi;
    hi = (longint'(1) <<< (sit_pkg::INT_BITS - 1 + FB)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint to_q(longint c);
    return c * (longint'(1) <<< (FB - sit_pkg::COORD_FRAC));
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // Slope times coordinate, truncated toward zero; the product magnitude is
  // capped well above the saturation range so that it cannot wrap.
  function automatic longint slope_times_x(longint m, longint x);
    longint unsigned mm, mx, p;
    mm = magnitude(m);
    mx = magnitude(x);
    if (mx != 0 && mm > (64'd1 << 62) / mx) p = 64'd1 << 62;
    else p = mm * mx;
    p = p >> sit_pkg::COORD_FRAC;
    return ((m < 0) != (x < 0)) ? -longint'(p) : longint'(p);
  endfunction

  // Fixed-point quotient with FB fraction bits, toward zero, saturated.
  function automatic longint quotient_q(longint n, longint d);
    longint unsigned un, ud, q, r;
    un = magnitude(n);
    ud = magnitude(d);
    q = un / ud;
    r = un % ud;
    for (int i = 0; i < FB; i++) begin
      if (q > (64'd1 << 60)) begin
        q = 64'd1 << 60;
        break;
      end
      r = r << 1;
      q = q << 1;
      if (r >= ud) begin
        r = r - ud;
        q = q | 64'd1;
      end
    end
    if (q > (64'd1 << 60)) q = 64'd1 << 60;
    return sat_q(((n < 0) != (d < 0)) ? -longint'(q) : longint'(q));
  endfunction

  function automatic segment_t build_segment(longint x0, longint y0, longint x1, longint y1);
    segment_t s;
    longint unsigned q;
    s.x0 = x0;
    s.y0 = y0;
    s.xmin = x0 < x1 ? x0 : x1;
    s.xmax = x0 < x1 ? x1 : x0;
    s.ymin = y0 < y1 ? y0 : y1;
    s.ymax = y0 < y1 ? y1 : y0;
    s.vert = (x0 == x1);
    s.horiz = (y0 == y1);
    s.m = 0;
    s.b = 0;
    if (!s.vert) begin
      q = (magnitude(y0 - y1) << FB) / magnitude(x0 - x1);
      s.m = sat_q(((y0 - y1 < 0) != (x0 - x1 < 0)) ? -longint'(q) : longint'(q));
      s.b = sat_q(to_q(y0) - slope_times_x(s.m, x0));
    end
    return s;
  endfunction

  // v is vertical and o is not.
  function automatic bit vertical_hits(segment_t v, segment_t o);
    longint y;
    y = sat_q(slope_times_x(o.m, v.xmin) + o.b);
    if (v.xmin < o.xmin || v.xmin > o.xmax) return 1'b0;
    return to_q(v.ymin) <= y && y <= to_q(v.ymax);
  endfunction

  function automatic bit predict_crosses(logic [8*CB-1:0] w);
    segment_t a, c;
    longint x;
    a = build_segment(longint'($signed(w[0*CB +: CB])), longint'($signed(w[1*CB +: CB])),
                      longint'($signed(w[2*CB +: CB])), longint'($signed(w[3*CB +: CB])));
    c = build_segment(longint'($signed(w[4*CB +: CB])), longint'($signed(w[5*CB +: CB])),
                      longint'($signed(w[6*CB +: CB])), longint'($signed(w[7*CB +: CB])));
    if (a.vert && c.vert)
      return a.xmin == c.xmin && a.ymin <= c.ymax && c.ymin <= a.ymax;
    if (a.vert) return vertical_hits(a, c);
    if (c.vert) return vertical_hits(c, a);
    if (a.horiz && c.horiz)
      return a.ymin == c.ymin && a.xmin <= c.xmax && c.xmin <= a.xmax;
    if (a.m == c.m) return 1'b0;
    x = quotient_q(c.b - a.b, a.m - c.m);
    return to_q(a.xmin) <= x && x <= to_q(a.xmax) && to_q(c.xmin) <= x && x <= to_q(c.xmax);
  endfunction

  function automatic logic [8*CB-1:0] pack_pair(int ax0, int ay0, int ax1, int ay1,
                                                int cx0, int cy0, int cx1, int cy1);
    return {CB'(cy1), CB'(cx1), CB'(cy0), CB'(cx0), CB'(ay1), CB'(ax1), CB'(ay0), CB'(ax0)};
  endfunction

  // A coordinate biased toward small values and the extremes.
  function automatic int rand_coord();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 32767 : -32768;
      1, 2:    return int'($signed(CB'($urandom())));
      default: return int'($urandom_range(0, 256)) - 128;
    endcase
  endfunction

  // Random pair shaped to fall often into every case of the test.
  function automatic logic [8*CB-1:0] random_pair();
    int p[8];
    foreach (p[i]) p[i] = rand_coord();
    case ($urandom_range(0, 7))
      0: begin
        p[2] = p[0];
        p[6] = p[4];
        if ($urandom_range(0, 1)) p[4] = p[0];
        p[6] = p[4];
      end
      1: p[2] = p[0];
      2: p[6] = p[4];
      3: begin
        p[3] = p[1];
        p[7] = p[5];
        if ($urandom_range(0, 1)) begin
          p[5] = p[1];
          p[7] = p[1];
        end
      end
      4: begin
        // Segments that share an endpoint.
        p[4] = p[2];
        p[5] = p[3];
      end
      5: begin
        // Parallel shifted copy.
        p[4] = p[0] + 16;
        p[6] = p[2] + 16;
        p[5] = p[1] - 4;
        p[7] = p[3] - 4;
      end
      default: ;
    endcase
    return pack_pair(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
  endfunction

  // Directed stimulus; want is 0/1 where the answer is obvious, -1 otherwise.
  logic [8*CB-1:0] directed_word[NUM_DIRECTED];
  int              directed_want[NUM_DIRECTED];

  initial begin
    directed_word[0]  = pack_pair(0, 0, 0, 0, 0, 0, 0, 0);               directed_want[0]  = 1;
    directed_word[1]  = pack_pair(0, -16, 0, 16, -16, 0, 16, 0);         directed_want[1]  = 1;
    directed_word[2]  = pack_pair(16, 0, 16, 32, 16, 16, 16, 64);        directed_want[2]  = 1;
    directed_word[3]  = pack_pair(16, 0, 16, 32, 32, 0, 32, 32);         directed_want[3]  = 0;
    directed_word[4]  = pack_pair(0, 0, 0, 16, 0, 17, 0, 40);            directed_want[4]  = 0;
    directed_word[5]  = pack_pair(0, 5, 64, 5, 64, 5, 90, 5);            directed_want[5]  = 1;
    directed_word[6]  = pack_pair(0, 5, 64, 5, 65, 5, 90, 5);            directed_want[6]  = 0;
    directed_word[7]  = pack_pair(0, 5, 64, 5, 0, 6, 64, 6);             directed_want[7]  = 0;
    directed_word[8]  = pack_pair(0, 0, 32, 32, 0, 16, 32, 48);          directed_want[8]  = 0;
    directed_word[9]  = pack_pair(-32, -32, 32, 32, -32, 32, 32, -32);   directed_want[9]  = 1;
    directed_word[10] = pack_pair(0, 0, 16, 16, 32, 0, 48, -16);         directed_want[10] = 0;
    directed_word[11] = pack_pair(-32768, -32768, 32767, 32767,
                                  -32768, 32767, 32767, -32768);         directed_want[11] = -1;
    directed_word[12] = pack_pair(32767, 32767, 32767, 32767,
                                  32767, 32767, 32767, 32767);           directed_want[12] = 1;
    directed_word[13] = pack_pair(-32768, -32768, -32768, 32767,
                                  -32768, 0, 32767, 0);                  directed_want[13] = -1;
    directed_word[14] = pack_pair(0, -32768, 1, 32767, -32768, 0, 32767, 1); directed_want[14] = -1;
    directed_word[15] = pack_pair(-32768, 32767, 32767, -32768, 5, 5, 5, 5); directed_want[15] = -1;
    directed_word[16] = pack_pair(0, 0, 0, 64, 64, 0, 128, 64);          directed_want[16] = 0;
    directed_word[17] = pack_pair(-1, -1, -1, -1, -1, -1, 3, 7);         directed_want[17] = 1;
    directed_word[18] = pack_pair(0, 0, 3, 1, 0, 1, 3, 0);               directed_want[18] = -1;
    directed_word[19] = pack_pair(-32768, 1, 32767, 1, 0, -32768, 0, 32767); directed_want[19] = 1;
    directed_word[20] = pack_pair(-21846, 21845, 21845, -21846,
                                  -21846, -21846, 21845, 21845);         directed_want[20] = -1;
    directed_word[21] = pack_pair(0, 0, 1, 32767, 1, 0, 0, 32767);       directed_want[21] = -1;
  end

  // Hand one word to the core and queue its expected flag. Valid stays high
  // after the handshake and drops only when the sender goes idle.
  task automatic send_word(logic [8*CB-1:0] w, int want);
    bit predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    predicted = predict_crosses(w);
    if (want >= 0 && predicted != want[0]) begin
      $display("%0t: directed word %h expected %0d, predictor gives %0d",
               $time, w, want, predicted);
      error_count++;
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= w;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_crosses.push_back(want >= 0 ? want[0] : predicted);
    words_sent++;
  endtask

  // Receiver: random backpressure, compares every accepted word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_crosses.size() == 0) begin
          $display("%0t: unexpected word %h", $time, m_axis_tdata_o);
          error_count++;
        end else begin
          if (m_axis_tdata_o !== {7'b0, expected_crosses[0]}) begin
            $display("%0t: crosses expected %0d, actual %h",
                     $time, expected_crosses[0], m_axis_tdata_o);
            error_count++;
          end
          crossings_seen += expected_crosses[0];
          void'(expected_crosses.pop_front());
          words_checked++;
        end
      end
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_crosses.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) send_word(directed_word[i], directed_want[i]);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM / 3) begin
        // Hold off the sender until the pipeline has emptied completely.
        drain();
        send_idle_pct = 69;
        recv_idle_pct = 19;
      end
      if (i == 2 * NUM_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_word(random_pair(), -1);
    end

    drain();
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("Checked %0d of %0d segment pairs, %0d of them touching, across",
             words_checked, words_sent, crossings_seen);
    $display("vertical, horizontal, parallel, general and saturating cases.");
    if (error_count == 0 && expected_crosses.size() == 0) begin
      $display("PASS segment_intersection_test_core");
    end else begin
      $display("FAIL segment_intersection_test_core");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #3000000;
    $display("FAIL segment_intersection_test_core");
    $finish;
  end

endmodule
